[src/oal_pkg.sv]
package oal_pkg;

	localparam int MODE_W    = 3;
	localparam int POS_W     = 7;
	localparam int VALUE_W   = 32;
	localparam int IDX_W     = 7;
	localparam int CNT_W     = 7;
	localparam int STAT_W    = 2;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 16;

	// match bits examined per scan cycle
	localparam int GROUP = 8;

	localparam logic [IDX_W-1:0] FOUND_NONE = '1;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 3'd0,
		MODE_ERASE  = 3'd1,
		MODE_MODIFY = 3'd2,
		MODE_FIND   = 3'd3,
		MODE_PUSH   = 3'd4,
		MODE_POP    = 3'd5
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_EMPTY  = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ERASE,
		CELL_WRITE
	} cell_op_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_SCAN
	} fsm_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_stat_t;

endpackage

[src/oal_cell.sv]
module oal_cell import oal_pkg::*; #(
	parameter int IDX        = 0,
	parameter int CW         = 7,
	parameter int WORD_WIDTH = 32
) (
	input  logic                  clk,
	input  cell_op_t              op,
	input  logic [CW-1:0]         pos,
	input  logic [CW-1:0]         count,
	input  logic [WORD_WIDTH-1:0] word,
	input  logic [WORD_WIDTH-1:0] left,
	input  logic [WORD_WIDTH-1:0] right,
	output logic [WORD_WIDTH-1:0] data,
	output logic                  match
);

	localparam logic [CW-1:0] MY = CW'(IDX);

	logic [WORD_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_INSERT: begin
				if (MY == pos) begin
					data_q <= word;
				end else if (MY > pos) begin
					data_q <= left;
				end
			end
			CELL_ERASE: begin
				if (MY >= pos) begin
					data_q <= right;
				end
			end
			CELL_WRITE: begin
				if (MY == pos) begin
					data_q <= word;
				end
			end
			default: begin
			end
		endcase
	end

	assign data  = data_q;
	// only live entries take part in a search
	assign match = (data_q == word) && (MY < count);

endmodule

[src/oal_scan.sv]
module oal_scan import oal_pkg::*; #(
	parameter  int DEPTH = 64,
	localparam int NC    = (DEPTH + GROUP - 1) / GROUP,
	localparam int NV    = NC * GROUP,
	localparam int CHW   = (NC > 1) ? $clog2(NC) : 1,
	localparam int LGW   = $clog2(GROUP),
	localparam int IW    = CHW + LGW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             step,
	input  logic [DEPTH-1:0] match,
	output scan_stat_t       stat,
	output logic [IW-1:0]    index
);

	logic [NV-1:0]  vector_q;
	logic [CHW-1:0] chunk_q;
	logic [LGW-1:0] enc;
	logic           last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
		end else if (load) begin
			chunk_q <= '0;
		end else if (step) begin
			chunk_q <= chunk_q + CHW'(1);
		end
	end

	// shift the match bits down one group per cycle while step is high
	always_ff @(posedge clk) begin
		if (load) begin
			vector_q <= NV'(match);
		end else if (step) begin
			vector_q <= vector_q >> GROUP;
		end
	end

	always_comb begin
		enc = '0;
		for (int k = GROUP - 1; k >= 0; k--) begin
			if (vector_q[k]) begin
				enc = LGW'(k);
			end
		end
	end

	assign last      = (chunk_q == CHW'(NC - 1));
	assign stat.hit  = |vector_q[GROUP-1:0];
	assign stat.done = stat.hit || last;
	assign index     = {chunk_q, enc};

endmodule

[src/ordered_array_list.sv]
// channel  dir  fields (tdata/tuser from bit 0 up)
// s_*      in   tdata: mode[2:0] position[9:3] value[41:10], zero pad to 48
// m_*      out  tdata: found_index[6:0] entry_count[13:7] status[15:14]
//
// Insert, erase, modify, push, pop and unused modes are handled in the accept
// cycle: cells shift or load as the mode needs and the result is registered.
// Find: cells compare in the accept cycle and the scanner loads the match bits,
// then walks them eight per cycle until a hit or the last group.
// arst_n clears the count, the controller and the output valid; entries are
// not cleared. A stalled output holds the block: no new item until it drains.
module ordered_array_list import oal_pkg::*; #(
	parameter int DEPTH      = 64,
	parameter int WORD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // mode, position, value
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // found_index, entry_count, status
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam int NC   = (DEPTH + GROUP - 1) / GROUP;
	localparam int CHW  = (NC > 1) ? $clog2(NC) : 1;
	localparam int IW   = CHW + $clog2(GROUP);

	fsm_t                  state_q, state_d;
	logic [CW-1:0]         count_q, count_d;
	cell_op_t              cell_op;
	logic [CW-1:0]         cell_pos;
	logic [WORD_WIDTH-1:0] word;
	logic signed [63:0]    value_x;
	logic [WORD_WIDTH-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]      match;
	scan_stat_t            sstat;
	logic [IW-1:0]         scan_idx;
	logic                  scan_load, scan_step;
	mode_t                 md;
	logic [POS_W-1:0]      position;
	logic [CMPW-1:0]       pos_x, cnt_x;
	logic                  out_free, out_load, s_accept;
	logic [IDX_W-1:0]      out_found;
	stat_t                 out_stat;
	logic                  m_tvalid_q;
	logic [IDX_W-1:0]      found_q;
	logic [CNT_W-1:0]      entry_count_q;
	stat_t                 status_q;

	assign md       = mode_t'(s_tdata[2:0]);
	assign position = s_tdata[9:3];
	assign value_x  = 64'(signed'(s_tdata[41:10]));
	assign word     = value_x[WORD_WIDTH-1:0];
	assign pos_x    = CMPW'(position);
	assign cnt_x    = CMPW'(count_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = word;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		oal_cell #(
			.IDX        (i),
			.CW         (CW),
			.WORD_WIDTH (WORD_WIDTH)
		) u_cell (
			.clk   (clk),
			.op    (cell_op),
			.pos   (cell_pos),
			.count (count_q),
			.word  (word),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i]),
			.match (match[i])
		);
	end

	oal_scan #(
		.DEPTH (DEPTH)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (scan_load),
		.step   (scan_step),
		.match  (match),
		.stat   (sstat),
		.index  (scan_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		cell_op   = CELL_HOLD;
		cell_pos  = count_q;
		count_d   = count_q;
		out_load  = 1'b0;
		out_found = FOUND_NONE;
		out_stat  = STAT_OK;
		scan_load = 1'b0;
		scan_step = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				s_tready = out_free;
				if (s_tvalid && out_free) begin
					out_load = 1'b1;
					case (md)
						MODE_INSERT: begin
							if (pos_x > cnt_x) begin
								out_stat = STAT_BADPOS;
							end else if (count_q == CW'(DEPTH)) begin
								out_stat = STAT_FULL;
							end else begin
								cell_op  = CELL_INSERT;
								cell_pos = CW'(position);
								count_d  = count_q + CW'(1);
							end
						end
						MODE_PUSH: begin
							if (count_q == CW'(DEPTH)) begin
								out_stat = STAT_FULL;
							end else begin
								cell_op = CELL_INSERT;
								count_d = count_q + CW'(1);
							end
						end
						MODE_ERASE: begin
							if (count_q == '0) begin
								out_stat = STAT_EMPTY;
							end else if (pos_x >= cnt_x) begin
								out_stat = STAT_BADPOS;
							end else begin
								cell_op  = CELL_ERASE;
								cell_pos = CW'(position);
								count_d  = count_q - CW'(1);
							end
						end
						MODE_MODIFY: begin
							if (pos_x >= cnt_x) begin
								out_stat = STAT_BADPOS;
							end else begin
								cell_op  = CELL_WRITE;
								cell_pos = CW'(position);
							end
						end
						MODE_POP: begin
							if (count_q == '0) begin
								out_stat = STAT_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
							end
						end
						MODE_FIND: begin
							out_load  = 1'b0;
							scan_load = 1'b1;
							state_d   = FSM_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			FSM_SCAN: begin
				if (!sstat.done) begin
					scan_step = 1'b1;
				end else if (out_free) begin
					out_load  = 1'b1;
					out_found = sstat.hit ? IDX_W'(scan_idx) : FOUND_NONE;
					state_d   = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q       <= out_found;
			entry_count_q <= CNT_W'(count_d);
			status_q      <= out_stat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {status_q, entry_count_q, found_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_scan_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_SCAN |-> !s_tready)
		else $error("item accepted during search");

	a_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && md != MODE_FIND |=> m_tvalid)
		else $error("result missing after non-search item");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && found_q != FOUND_NONE |-> status_q == STAT_OK)
		else $error("found index with error status");

endmodule
